[rtl/assert_macros.svh]
// Assertion macros for the motor mixer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QXM_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qxm assertion failed");
`define QXM_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qxm assertion failed");
`else
`define QXM_ASSERT_RST(lbl, clk, rst_n, prop)
`define QXM_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

[rtl/qxm_pkg.sv]
// Types and constants of the quad-X motor mixer.
// No dependencies; imported by every RTL module, interface and bench file of the block.
`timescale 1ns / 1ps
`default_nettype none
package qxm_pkg;

    localparam int THR_W       = 8;
    localparam int CORR_W      = 12;
    localparam int YAW_W       = 8;
    localparam int LVL_W       = 11;
    localparam int LANES       = 4;
    localparam int MIX_W       = 15;
    localparam int SPAN_W      = 14;
    localparam int DIV_STEPS   = LVL_W;
    localparam int NUM_W       = SPAN_W + DIV_STEPS;
    localparam int PROD_W      = THR_W + LVL_W;
    localparam int RECIP_W     = 20;
    localparam int SCALED_W    = PROD_W + RECIP_W;
    // ceil(2^27 / 255): exact floor division by 255 for products below 2^19.
    localparam int RECIP       = 526345;
    localparam int RECIP_SHIFT = 27;
    localparam int STEPS_PER_STAGE = 4;
    localparam int LAST_STEPS  = DIV_STEPS - 2 * STEPS_PER_STAGE;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam logic [LVL_W-1:0] MAX_LEVEL_RST = 11'd1000;
    localparam logic REG_MAX_LEVEL = 1'b0;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_REMAP,
        MODE_SHIFT
    } t_mode;

    typedef struct packed {
        t_mode                             mode;
        logic [SPAN_W-1:0]                 span;
        logic [LANES-1:0][NUM_W-1:0]       num;
        logic [LANES-1:0][LVL_W-1:0]       shifted;
    } t_div_item;

endpackage
`default_nettype wire

[rtl/qxm_if.sv]
// Valid/ready channel interfaces for mixer commands and motor results.
// Depends on qxm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface qxm_cmd_if;
    import qxm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [THR_W-1:0]         throttle;
    logic signed [CORR_W-1:0] pitch_correction;
    logic signed [CORR_W-1:0] roll_correction;
    logic signed [YAW_W-1:0]  yaw_command;

    modport source (
        output valid, throttle, pitch_correction, roll_correction, yaw_command,
        input  ready
    );
    modport sink (
        input  valid, throttle, pitch_correction, roll_correction, yaw_command,
        output ready
    );
endinterface

interface qxm_motor_if;
    import qxm_pkg::*;

    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] front_left;
    logic [LVL_W-1:0] front_right;
    logic [LVL_W-1:0] rear_left;
    logic [LVL_W-1:0] rear_right;

    modport source (
        output valid, front_left, front_right, rear_left, rear_right,
        input  ready
    );
    modport sink (
        input  valid, front_left, front_right, rear_left, rear_right,
        output ready
    );
endinterface
`default_nettype wire

[rtl/qxm_cfg.sv]
// APB-style register file holding the full-scale motor level.
// Depends on qxm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qxm_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qxm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [qxm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [qxm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [qxm_pkg::LVL_W-1:0]       o_max_level
);
    import qxm_pkg::*;

    logic [LVL_W-1:0] r_max_level;
    logic             reg_index;
    logic             wr_en;

    assign reg_index = paddr[CFG_ADDR_W-1];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready && (reg_index == REG_MAX_LEVEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level <= MAX_LEVEL_RST;
        end else if (wr_en) begin
            r_max_level <= pwdata[LVL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_MAX_LEVEL) begin
            prdata = {{(CFG_DATA_W-LVL_W){1'b0}}, r_max_level};
        end
    end

    assign o_max_level = r_max_level;
endmodule
`default_nettype wire

[rtl/qxm_front.sv]
// Front pipeline: throttle scaling, quad-X mix, range search and remap numerators.
// Depends on qxm_pkg and qxm_if; feeds qxm_div.
`timescale 1ns / 1ps
`default_nettype none
module qxm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [qxm_pkg::LVL_W-1:0]  i_max_level,
    qxm_cmd_if.sink                    i_cmd,
    output logic                       o_valid,
    input  logic                       i_ready,
    output qxm_pkg::t_div_item         o_item
);
    import qxm_pkg::*;

    localparam int STAGES = 5;

    typedef logic signed [MIX_W-1:0] t_mix;

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] stg_ready;
    logic [STAGES-1:0] stg_load;

    logic [PROD_W-1:0]        r1_prod, n1_prod;
    logic signed [CORR_W-1:0] r1_p, r1_r, r2_p, r2_r;
    logic signed [YAW_W-1:0]  r1_y, r2_y;
    logic                     r1_zero, r2_zero, r3_zero, r4_zero;
    logic [SCALED_W-1:0]      n2_scaled;
    logic [LVL_W-1:0]         r2_thr;
    t_mix                     r3_m [LANES];
    t_mix                     n3_m [LANES];
    t_mix                     r4_m [LANES];
    t_mix                     r4_hi, r4_lo, n4_hi, n4_lo;
    t_div_item                r5_item, n5_item;

    always_comb begin
        stg_ready[STAGES-1] = !r_valid[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stg_ready[k] = !r_valid[k] || stg_ready[k+1];
        end
        stg_load[0] = stg_ready[0] && i_cmd.valid;
        for (int k = 1; k < STAGES; k++) begin
            stg_load[k] = stg_ready[k] && r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stg_ready[0]) begin
                r_valid[0] <= i_cmd.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (stg_ready[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Stage 1: throttle times full scale.
    assign n1_prod = PROD_W'(i_cmd.throttle) * PROD_W'(i_max_level);

    always_ff @(posedge i_clk) begin
        if (stg_load[0]) begin
            r1_prod <= n1_prod;
            r1_p    <= i_cmd.pitch_correction;
            r1_r    <= i_cmd.roll_correction;
            r1_y    <= i_cmd.yaw_command;
            r1_zero <= (i_cmd.throttle == '0);
        end
    end

    // Stage 2: division by 255 as a reciprocal multiplication.
    assign n2_scaled = SCALED_W'(r1_prod) * SCALED_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (stg_load[1]) begin
            r2_thr  <= n2_scaled[RECIP_SHIFT +: LVL_W];
            r2_p    <= r1_p;
            r2_r    <= r1_r;
            r2_y    <= r1_y;
            r2_zero <= r1_zero;
        end
    end

    // Stage 3: quad-X mix.
    always_comb begin
        t_mix t, p, r, y;
        t = $signed({{(MIX_W-LVL_W){1'b0}}, r2_thr});
        p = $signed({{(MIX_W-CORR_W){r2_p[CORR_W-1]}}, r2_p});
        r = $signed({{(MIX_W-CORR_W){r2_r[CORR_W-1]}}, r2_r});
        y = $signed({{(MIX_W-YAW_W){r2_y[YAW_W-1]}}, r2_y});
        n3_m[0] = t - p - y + r;
        n3_m[1] = t - p + y - r;
        n3_m[2] = t + p + y + r;
        n3_m[3] = t + p - y - r;
    end

    always_ff @(posedge i_clk) begin
        if (stg_load[2]) begin
            r3_m    <= n3_m;
            r3_zero <= r2_zero;
        end
    end

    // Stage 4: largest and smallest motor value.
    always_comb begin
        t_mix hi_a, hi_b, lo_a, lo_b;
        hi_a  = (r3_m[0] > r3_m[1]) ? r3_m[0] : r3_m[1];
        lo_a  = (r3_m[0] < r3_m[1]) ? r3_m[0] : r3_m[1];
        hi_b  = (r3_m[2] > r3_m[3]) ? r3_m[2] : r3_m[3];
        lo_b  = (r3_m[2] < r3_m[3]) ? r3_m[2] : r3_m[3];
        n4_hi = (hi_a > hi_b) ? hi_a : hi_b;
        n4_lo = (lo_a < lo_b) ? lo_a : lo_b;
    end

    always_ff @(posedge i_clk) begin
        if (stg_load[3]) begin
            r4_m    <= r3_m;
            r4_hi   <= n4_hi;
            r4_lo   <= n4_lo;
            r4_zero <= r3_zero;
        end
    end

    // Stage 5: spread, mode, remap numerators and shifted values.
    always_comb begin
        t_mix              full_s, diff_full, spread, d, v;
        logic [SPAN_W-1:0] span;
        full_s    = $signed({{(MIX_W-LVL_W){1'b0}}, i_max_level});
        spread    = r4_hi - r4_lo;
        span      = spread[SPAN_W-1:0];
        diff_full = full_s - r4_hi;
        n5_item.span = span;
        if (r4_zero) begin
            n5_item.mode = MODE_ZERO;
        end else if (span > SPAN_W'(i_max_level)) begin
            n5_item.mode = MODE_REMAP;
        end else begin
            n5_item.mode = MODE_SHIFT;
        end
        for (int l = 0; l < LANES; l++) begin
            d = r4_m[l] - r4_lo;
            n5_item.num[l] = NUM_W'(d[SPAN_W-1:0]) * NUM_W'(i_max_level);
            if (r4_hi > full_s) begin
                v = r4_m[l] + diff_full;
            end else if (r4_lo[MIX_W-1]) begin
                v = d;
            end else begin
                v = r4_m[l];
            end
            n5_item.shifted[l] = v[LVL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_load[4]) begin
            r5_item <= n5_item;
        end
    end

    assign i_cmd.ready = stg_ready[0];
    assign o_valid     = r_valid[STAGES-1];
    assign o_item      = r5_item;
endmodule
`default_nettype wire

[rtl/qxm_div.sv]
// Pipelined restoring divider for the remap, with final motor selection.
// Depends on qxm_pkg, qxm_if and assert_macros.svh; fed by qxm_front.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module qxm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [qxm_pkg::LVL_W-1:0]  i_max_level,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  qxm_pkg::t_div_item         i_item,
    qxm_motor_if.source                o_motor
);
    import qxm_pkg::*;

    typedef struct packed {
        t_mode                        mode;
        logic [SPAN_W-1:0]            span;
        logic [LANES-1:0][SPAN_W-1:0] rem;
        logic [LANES-1:0][LVL_W-1:0]  low;
        logic [LANES-1:0][LVL_W-1:0]  quo;
        logic [LANES-1:0][LVL_W-1:0]  shifted;
    } t_div_stage;

    function automatic t_div_stage div_steps(input t_div_stage s, input int count);
        t_div_stage        x;
        logic [SPAN_W:0]   t;
        x = s;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            if (k < count) begin
                for (int l = 0; l < LANES; l++) begin
                    t = {x.rem[l], x.low[l][LVL_W-1]};
                    x.low[l] = {x.low[l][LVL_W-2:0], 1'b0};
                    if (t >= {1'b0, x.span}) begin
                        t = t - {1'b0, x.span};
                        x.quo[l] = {x.quo[l][LVL_W-2:0], 1'b1};
                    end else begin
                        x.quo[l] = {x.quo[l][LVL_W-2:0], 1'b0};
                    end
                    x.rem[l] = t[SPAN_W-1:0];
                end
            end
        end
        return x;
    endfunction

    logic [1:0]                  r_valid;
    logic                        r_out_valid;
    logic [1:0]                  stg_ready;
    logic                        out_ready;
    t_div_stage                  r_st [2];
    t_div_stage                  n_st0, n_st1, fin;
    t_div_stage                  init;
    logic [LANES-1:0][LVL_W-1:0] r_motor, n_motor;
    t_mode                       r_out_mode;

    assign out_ready    = !r_out_valid || o_motor.ready;
    assign stg_ready[1] = !r_valid[1] || out_ready;
    assign stg_ready[0] = !r_valid[0] || stg_ready[1];
    assign o_ready      = stg_ready[0];

    always_comb begin
        init.mode    = i_item.mode;
        init.span    = i_item.span;
        init.shifted = i_item.shifted;
        for (int l = 0; l < LANES; l++) begin
            init.rem[l] = i_item.num[l][NUM_W-1:DIV_STEPS];
            init.low[l] = i_item.num[l][DIV_STEPS-1:0];
            init.quo[l] = '0;
        end
        n_st0 = div_steps(init, STEPS_PER_STAGE);
        n_st1 = div_steps(r_st[0], STEPS_PER_STAGE);
        fin   = div_steps(r_st[1], LAST_STEPS);
        for (int l = 0; l < LANES; l++) begin
            case (fin.mode)
                MODE_ZERO:  n_motor[l] = '0;
                MODE_REMAP: n_motor[l] = fin.quo[l];
                default:    n_motor[l] = fin.shifted[l];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (stg_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            if (stg_ready[1]) begin
                r_valid[1] <= r_valid[0];
            end
            if (out_ready) begin
                r_out_valid <= r_valid[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_ready[0] && i_valid) begin
            r_st[0] <= n_st0;
        end
        if (stg_ready[1] && r_valid[0]) begin
            r_st[1] <= n_st1;
        end
        if (out_ready && r_valid[1]) begin
            r_motor    <= n_motor;
            r_out_mode <= fin.mode;
        end
    end

    assign o_motor.valid       = r_out_valid;
    assign o_motor.front_left  = r_motor[0];
    assign o_motor.front_right = r_motor[1];
    assign o_motor.rear_left   = r_motor[2];
    assign o_motor.rear_right  = r_motor[3];

    `QXM_ASSERT_RST(a_motor_in_range, i_clk, i_rst_n, r_out_valid |-> (r_motor[0] <= i_max_level) && (r_motor[1] <= i_max_level) && (r_motor[2] <= i_max_level) && (r_motor[3] <= i_max_level))
    `QXM_ASSERT_RST(a_remap_full_range, i_clk, i_rst_n, (r_out_valid && r_out_mode == MODE_REMAP) |-> ((r_motor[0] == '0) || (r_motor[1] == '0) || (r_motor[2] == '0) || (r_motor[3] == '0)) && ((r_motor[0] == i_max_level) || (r_motor[1] == i_max_level) || (r_motor[2] == i_max_level) || (r_motor[3] == i_max_level)))
    `QXM_ASSERT_RST(a_rem_below_span, i_clk, i_rst_n, (r_valid[1] && r_st[1].mode == MODE_REMAP) |-> (r_st[1].rem[0] < r_st[1].span) && (r_st[1].rem[1] < r_st[1].span) && (r_st[1].rem[2] < r_st[1].span) && (r_st[1].rem[3] < r_st[1].span))
endmodule
`default_nettype wire

[rtl/quad_x_motor_mixer_desaturate.sv]
// Channel  | Direction | Payload
// i_cmd    | in        | throttle, pitch_correction, roll_correction, yaw_command
// o_motor  | out       | front_left, front_right, rear_left, rear_right
// APB      | in/out    | max_motor_level at byte address 0
// One item is accepted per cycle while o_motor is not stalled; new items enter before earlier ones leave.
// The pipeline is made of the five front stages (two multiplications, mix, range, numerators)
// and three stages of the restoring divider, which yield four, four and three quotient bits.
// Reset is synchronous and clears only valid bits and the full-scale register (1000).
// Each stage holds its item while the next cannot take it, so bubbles fill up under a stall.
// Top level of the quad-X motor mixer; depends on qxm_pkg, qxm_if, qxm_cfg,
// qxm_front and qxm_div.
`timescale 1ns / 1ps
`default_nettype none
module quad_x_motor_mixer_desaturate (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qxm_cmd_if.sink                         i_cmd,
    qxm_motor_if.source                     o_motor,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qxm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [qxm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [qxm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import qxm_pkg::*;

    logic [LVL_W-1:0] max_level;
    logic             mid_valid;
    logic             mid_ready;
    t_div_item        mid_item;

    qxm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_level (max_level)
    );

    qxm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_level (max_level),
        .i_cmd       (i_cmd),
        .o_valid     (mid_valid),
        .i_ready     (mid_ready),
        .o_item      (mid_item)
    );

    qxm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_level (max_level),
        .i_valid     (mid_valid),
        .o_ready     (mid_ready),
        .i_item      (mid_item),
        .o_motor     (o_motor)
    );
endmodule
`default_nettype wire

[bench/qxm_motor_checker.sv]
// Checker for the quad-X motor mixer: watches the command, motor and APB ports,
// predicts every motor item and compares it with what the block delivers.
// Depends on qxm_pkg and qxm_if.
`timescale 1ns / 1ps
module qxm_motor_checker
    import qxm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qxm_cmd_if                    i_cmd,
    qxm_motor_if                  i_motor,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int THR_FULL = 255;

    typedef struct packed {
        logic [LVL_W-1:0] front_left;
        logic [LVL_W-1:0] front_right;
        logic [LVL_W-1:0] rear_left;
        logic [LVL_W-1:0] rear_right;
    } t_motor_set;

    logic [LVL_W-1:0] full_scale = MAX_LEVEL_RST;
    t_motor_set       expected_motors[$];
    int               error_count = 0;

    function automatic t_motor_set mix_and_desaturate(
        input logic [LVL_W-1:0]         level,
        input logic [THR_W-1:0]         thr,
        input logic signed [CORR_W-1:0] pitch,
        input logic signed [CORR_W-1:0] roll,
        input logic signed [YAW_W-1:0]  yaw
    );
        int         lvl;
        int         base;
        int         p;
        int         r;
        int         y;
        int         hi;
        int         lo;
        int         m[4];
        t_motor_set res;
        res = '0;
        if (thr == '0) begin
            return res;
        end
        lvl = int'(level);
        p = pitch;
        r = roll;
        y = yaw;
        base = int'(thr) * lvl / THR_FULL;
        m[0] = base - p - y + r;
        m[1] = base - p + y - r;
        m[2] = base + p + y + r;
        m[3] = base + p - y - r;
        hi = m[0];
        lo = m[0];
        for (int i = 1; i < 4; i++) begin
            if (m[i] > hi) hi = m[i];
            if (m[i] < lo) lo = m[i];
        end
        if (hi - lo > lvl) begin
            for (int i = 0; i < 4; i++) m[i] = (m[i] - lo) * lvl / (hi - lo);
        end else if (hi > lvl) begin
            for (int i = 0; i < 4; i++) m[i] = m[i] - (hi - lvl);
        end else if (lo < 0) begin
            for (int i = 0; i < 4; i++) m[i] = m[i] - lo;
        end
        res.front_left  = LVL_W'(m[0]);
        res.front_right = LVL_W'(m[1]);
        res.rear_left   = LVL_W'(m[2]);
        res.rear_right  = LVL_W'(m[3]);
        return res;
    endfunction

    function automatic int field_mismatch(input string name, input logic [LVL_W-1:0] want,
                                          input logic [LVL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_motor_set got;
        t_motor_set want;
        if (!i_rst_n) begin
            full_scale = MAX_LEVEL_RST;
            expected_motors.delete();
        end else begin
            if (i_motor.valid && i_motor.ready) begin
                got.front_left  = i_motor.front_left;
                got.front_right = i_motor.front_right;
                got.rear_left   = i_motor.rear_left;
                got.rear_right  = i_motor.rear_right;
                if (expected_motors.size() == 0) begin
                    $display("%0t: motor item expected none, got %p", $time, got);
                    error_count++;
                end else begin
                    want = expected_motors.pop_front();
                    error_count += field_mismatch("front_left", want.front_left,
                                                  got.front_left);
                    error_count += field_mismatch("front_right", want.front_right,
                                                  got.front_right);
                    error_count += field_mismatch("rear_left", want.rear_left,
                                                  got.rear_left);
                    error_count += field_mismatch("rear_right", want.rear_right,
                                                  got.rear_right);
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                expected_motors.push_back(mix_and_desaturate(full_scale, i_cmd.throttle,
                    i_cmd.pitch_correction, i_cmd.roll_correction, i_cmd.yaw_command));
            end
            if (psel && penable && pwrite && pready
                    && paddr == CFG_ADDR_W'(4 * REG_MAX_LEVEL)) begin
                full_scale = pwdata[LVL_W-1:0];
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_motors.size();
    end

endmodule

[bench/quad_x_motor_mixer_desaturate_tb.sv]
// Testbench top for the quad-X motor mixer: drives commands, full-scale writes and
// motor back-pressure, and reports the verdict of the checker beside the block.
// Depends on qxm_pkg, qxm_if, qxm_motor_checker and the mixer RTL.
`timescale 1ns / 1ps
module quad_x_motor_mixer_desaturate_tb;
    import qxm_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    errors;
    int                    pending;
    int                    cycle_count = 0;
    bit                    tx_idle = 1'b1;
    bit                    rx_idle = 1'b1;
    bit                    long_hold = 1'b0;

    qxm_cmd_if   cmd_ch ();
    qxm_motor_if motor_ch ();

    quad_x_motor_mixer_desaturate uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_motor (motor_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    qxm_motor_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_ch),
        .i_motor   (motor_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        motor_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                motor_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
                motor_ch.ready <= 1'b1;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                motor_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                motor_ch.ready <= 1'b1;
            end else begin
                motor_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    task automatic send_cmd(input int thr, input int pitch, input int roll, input int yaw);
        cmd_ch.valid            <= 1'b1;
        cmd_ch.throttle         <= THR_W'(thr);
        cmd_ch.pitch_correction <= CORR_W'(pitch);
        cmd_ch.roll_correction  <= CORR_W'(roll);
        cmd_ch.yaw_command      <= YAW_W'(yaw);
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic int pick_correction();
        case ($urandom_range(0, 2))
            0:       return int'($urandom);
            1:       return int'($urandom_range(0, 160)) - 80;
            default: return int'($urandom_range(0, 1200)) - 600;
        endcase
    endfunction

    task automatic send_random(input int count);
        int thr;
        int yaw;
        for (int n = 0; n < count; n++) begin
            thr = ($urandom_range(0, 19) == 0) ? 0 : int'($urandom_range(0, 255));
            yaw = ($urandom_range(0, 1) == 0) ? int'($urandom)
                                              : int'($urandom_range(0, 40)) - 20;
            send_cmd(thr, pick_correction(), pick_correction(), yaw);
        end
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_full_scale(input logic [LVL_W-1:0] level);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * REG_MAX_LEVEL);
        pwdata  <= CFG_DATA_W'(level);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        cmd_ch.valid            <= 1'b0;
        cmd_ch.throttle         <= '0;
        cmd_ch.pitch_correction <= '0;
        cmd_ch.roll_correction  <= '0;
        cmd_ch.yaw_command      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(0, 2047, -2048, 127);
        send_cmd(0, -2048, 2047, -128);
        send_cmd(255, 0, 0, 0);
        send_cmd(1, 0, 0, 0);
        send_cmd(255, 100, 0, 0);
        send_cmd(10, 0, 50, 0);
        send_cmd(128, 2047, 2047, 127);
        send_cmd(255, -2048, -2048, -128);
        send_cmd(200, -2048, 2047, 127);
        send_cmd(50, 0, 0, -128);
        send_cmd(50, 0, 0, 127);
        send_cmd(255, 2047, 0, 0);
        send_cmd(1, -1, -1, -1);
        send_cmd(128, 1, 2, 3);
        send_cmd(128, 0, -500, 0);
        send_cmd(255, 0, 0, -128);
        send_random(110);
        wait_drained();

        write_full_scale(11'd2047);
        tx_idle = 1'b0;
        send_cmd(255, 0, 0, 0);
        send_cmd(255, 2047, 2047, 127);
        send_random(110);
        wait_drained();

        write_full_scale(11'd1);
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        send_cmd(255, 0, 0, 0);
        send_cmd(1, 0, 0, 0);
        send_random(80);
        wait_drained();

        write_full_scale(11'd0);
        rx_idle = 1'b1;
        send_cmd(255, 0, 0, 0);
        send_cmd(255, -2048, 2047, -128);
        send_random(40);
        wait_drained();

        write_full_scale(LVL_W'($urandom_range(1, 2047)));
        tx_idle = 1'b0;
        long_hold = 1'b1;
        send_random(60);
        tx_idle = 1'b1;
        send_random(100);
        wait_drained();
        send_random(100);
        wait_drained();

        write_full_scale(LVL_W'($urandom_range(1, 2047)));
        send_random(60);
        wait_drained();

        write_full_scale(MAX_LEVEL_RST);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random(120);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/qxm_pkg.sv
rtl/qxm_if.sv
rtl/qxm_cfg.sv
rtl/qxm_front.sv
rtl/qxm_div.sv
rtl/quad_x_motor_mixer_desaturate.sv
bench/qxm_motor_checker.sv
bench/quad_x_motor_mixer_desaturate_tb.sv
